>>> rtl/mlbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types and codes for the multi-LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

    localparam int KIND_W  = 3;
    localparam int INDEX_W = 2;
    localparam int COUNT_W = 8;
    localparam int FIELD_PERIOD_W = 16;
    localparam int TOGGLES_W = COUNT_W + 1;
    localparam int SHOWN_LEDS = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_ON     = 3'd1,
        KIND_OFF    = 3'd2,
        KIND_TOGGLE = 3'd3,
        KIND_BLINK  = 3'd4
    } kind_t;

    // What one LED channel is told to do for the word in flight.
    typedef struct packed {
        logic                tick;
        logic                sel;
        kind_t               op;
        logic [COUNT_W-1:0]  count;
    } led_cmd_t;

endpackage : mlbc_pkg
`default_nettype wire

>>> rtl/mlbc_led.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_led
// State and update logic of one LED: level, blink period, timer and the
// number of toggles still to go.
// ----------------------------------------------------------------------------
module mlbc_led
    import mlbc_pkg::*;
#(
    parameter int PERIOD_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire led_cmd_t               cmd,
    input  wire logic [PERIOD_BITS-1:0] period,
    output logic                        lit_next,
    output logic                        blinking_next
);

    logic                   lit_reg;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [TOGGLES_W-1:0]   toggles_reg, toggles_next;
    logic                   endless_reg, endless_next;
    logic [PERIOD_BITS-1:0] elapsed_reg, elapsed_next;
    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic [TOGGLES_W-1:0]   toggles_dec;

    assign elapsed_inc = elapsed_reg + {{(PERIOD_BITS-1){1'b0}}, 1'b1};
    assign toggles_dec = toggles_reg - {{(TOGGLES_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        lit_next     = lit_reg;
        period_next  = period_reg;
        toggles_next = toggles_reg;
        endless_next = endless_reg;
        elapsed_next = elapsed_reg;
        if (cmd.tick)
        begin
            if (period_reg != '0)
            begin
                if (elapsed_inc >= period_reg)
                begin
                    lit_next     = ~lit_reg;
                    elapsed_next = '0;
                    if (!endless_reg)
                    begin
                        toggles_next = toggles_dec;
                        if (toggles_dec == '0)
                        begin
                            // The final toggle of a counted sequence ends it.
                            period_next  = '0;
                            endless_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
        else if (cmd.sel)
        begin
            // Every command cancels a running blink sequence first.
            period_next  = '0;
            toggles_next = '0;
            endless_next = 1'b0;
            elapsed_next = '0;
            case (cmd.op)
                KIND_ON:     lit_next = 1'b1;
                KIND_OFF:    lit_next = 1'b0;
                KIND_TOGGLE: lit_next = ~lit_reg;
                KIND_BLINK:
                begin
                    lit_next = 1'b1;
                    if (period != '0)
                    begin
                        period_next  = period;
                        endless_next = (cmd.count == '0);
                        toggles_next = (cmd.count == '0) ? '0
                                     : {cmd.count, 1'b0} - {{(TOGGLES_W-1){1'b0}}, 1'b1};
                    end
                end
                default:     lit_next = lit_reg;
            endcase
        end
    end

    assign blinking_next = (period_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg     <= 1'b0;
            period_reg  <= '0;
            toggles_reg <= '0;
            endless_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            lit_reg     <= lit_next;
            period_reg  <= period_next;
            toggles_reg <= toggles_next;
            endless_reg <= endless_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule : mlbc_led
`default_nettype wire

>>> rtl/multi_led_blink_controller.sv
`default_nettype none
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while the result side does not stall; every LED channel updates in parallel.
// A stall on the result side holds the result register and reaches the input
// side in the same cycle once the input register is full.
// Reset: all LEDs off, no blink sequences, both pipeline registers empty.
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Ticks and on/off/toggle/blink commands for a bank of LEDs; returns the lit
// mask, active-low pin levels and blinking mask after each word.
// ----------------------------------------------------------------------------
module multi_led_blink_controller
    import mlbc_pkg::*;
#(
    parameter int NUM_LEDS    = 4,
    parameter int PERIOD_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic [KIND_W-1:0]         kind,
    input  wire logic [INDEX_W-1:0]        led_index,
    input  wire logic [COUNT_W-1:0]        blink_count,
    input  wire logic [FIELD_PERIOD_W-1:0] blink_period,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic [SHOWN_LEDS-1:0]          led_on,
    output logic [SHOWN_LEDS-1:0]          pin_level,
    output logic [SHOWN_LEDS-1:0]          blinking
);

    logic                   s1_valid_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] period_in;
    logic                   result_valid_reg;
    logic [SHOWN_LEDS-1:0]  led_on_reg;
    logic [SHOWN_LEDS-1:0]  blinking_reg;
    logic                   advance;
    logic                   accept;
    logic                   is_tick;
    logic                   is_cmd;
    logic [NUM_LEDS-1:0]    lit_vec;
    logic [NUM_LEDS-1:0]    blink_vec;
    logic [SHOWN_LEDS-1:0]  led_on_next;
    logic [SHOWN_LEDS-1:0]  blinking_next;

    generate
        if (PERIOD_BITS <= FIELD_PERIOD_W)
        begin : g_period_trunc
            assign period_in = blink_period[PERIOD_BITS-1:0];
        end
        else
        begin : g_period_ext
            assign period_in = {{(PERIOD_BITS-FIELD_PERIOD_W){1'b0}}, blink_period};
        end
    endgenerate

    assign advance    = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            index_reg  <= led_index;
            count_reg  <= blink_count;
            period_reg <= period_in;
        end
    end

    assign is_tick = (kind_t'(kind_reg) == KIND_TICK);
    // Unused kinds and LEDs beyond the bank leave every channel untouched.
    assign is_cmd  = (kind_reg inside {KIND_ON, KIND_OFF, KIND_TOGGLE, KIND_BLINK})
                     && (32'(index_reg) < NUM_LEDS);

    genvar i;
    generate
        for (i = 0; i < NUM_LEDS; i++)
        begin : g_led
            led_cmd_t cmd;
            assign cmd = '{tick:  advance && is_tick,
                           sel:   advance && is_cmd && (32'(index_reg) == i),
                           op:    kind_t'(kind_reg),
                           count: count_reg};

            mlbc_led #(
                .PERIOD_BITS (PERIOD_BITS)
            ) u_led (
                .clk           (clk),
                .rst_n         (rst_n),
                .advance       (advance),
                .cmd           (cmd),
                .period        (period_reg),
                .lit_next      (lit_vec[i]),
                .blinking_next (blink_vec[i])
            );
        end

        for (i = 0; i < SHOWN_LEDS; i++)
        begin : g_show
            if (i < NUM_LEDS)
            begin : g_present
                assign led_on_next[i]   = lit_vec[i];
                assign blinking_next[i] = blink_vec[i];
            end
            else
            begin : g_absent
                assign led_on_next[i]   = 1'b0;
                assign blinking_next[i] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_on_reg   <= led_on_next;
            blinking_reg <= blinking_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign led_on       = led_on_reg;
    assign pin_level    = ~led_on_reg;
    assign blinking     = blinking_reg;

    // The input side only waits while both registers hold a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled with a free pipeline slot");

    // A word leaving the input register always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced word did not reach the result register");

    // Results held under stall keep their values.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> ($stable(led_on_reg) && $stable(blinking_reg)))
        else $error("stalled result changed");

endmodule : multi_led_blink_controller
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the multi-LED blink controller word by word. A tracker class follows
// every accepted input word with its own copy of the per-LED blink state and
// queues the expected lit, pin and blinking masks. Each accepted result word
// is compared against the oldest queued status. Stimulus starts with directed
// words and then runs random ticks and commands under three idle and stall
// mixes.
// ----------------------------------------------------------------------------
module testbench;
    import mlbc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_PER_PHASE = 245;
    localparam int SETTLE_CYCLES    = 10;

    typedef struct packed {
        logic [SHOWN_LEDS-1:0] on;
        logic [SHOWN_LEDS-1:0] pin;
        logic [SHOWN_LEDS-1:0] blink;
    } led_status_t;

    class led_state_tracker;
        bit                       lit          [SHOWN_LEDS];
        bit [FIELD_PERIOD_W-1:0]  period       [SHOWN_LEDS];
        bit [TOGGLES_W-1:0]       toggles_left [SHOWN_LEDS];
        bit                       endless      [SHOWN_LEDS];
        bit [FIELD_PERIOD_W-1:0]  elapsed      [SHOWN_LEDS];
        led_status_t              expected_status[$];
        int errors;
        int ticks;
        int blinks;
        int plain_cmds;
        int unused_words;
        int finished_sequences;
        int results_seen;

        function void halt(int i);
            period[i]       = '0;
            toggles_left[i] = '0;
            endless[i]      = 1'b0;
            elapsed[i]      = '0;
        endfunction

        function void advance_all();
            for (int i = 0; i < SHOWN_LEDS; i++)
            begin
                if (period[i] != 0)
                begin
                    elapsed[i] = elapsed[i] + 1'b1;
                    if (elapsed[i] >= period[i])
                    begin
                        lit[i]     = !lit[i];
                        elapsed[i] = '0;
                        if (!endless[i])
                        begin
                            toggles_left[i] = toggles_left[i] - 1'b1;
                            if (toggles_left[i] == 0)
                            begin
                                halt(i);
                                finished_sequences++;
                            end
                        end
                    end
                end
            end
        endfunction

        function void apply_word(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
                                 logic [COUNT_W-1:0] cnt,
                                 logic [FIELD_PERIOD_W-1:0] per);
            led_status_t s;
            if (k == KIND_TICK)
            begin
                ticks++;
                advance_all();
            end
            else if (k == KIND_ON || k == KIND_OFF || k == KIND_TOGGLE)
            begin
                plain_cmds++;
                halt(idx);
                if (k == KIND_ON)
                    lit[idx] = 1'b1;
                else if (k == KIND_OFF)
                    lit[idx] = 1'b0;
                else
                    lit[idx] = !lit[idx];
            end
            else if (k == KIND_BLINK)
            begin
                blinks++;
                halt(idx);
                lit[idx] = 1'b1;
                if (per != 0)
                begin
                    period[idx]       = per;
                    endless[idx]      = (cnt == 0);
                    toggles_left[idx] = (cnt != 0) ? TOGGLES_W'(2 * cnt - 1) : '0;
                end
            end
            else
                unused_words++;
            for (int i = 0; i < SHOWN_LEDS; i++)
            begin
                s.on[i]    = lit[i];
                s.pin[i]   = !lit[i];
                s.blink[i] = (period[i] != 0);
            end
            expected_status.push_back(s);
        endfunction

        function void report(string what, logic [SHOWN_LEDS-1:0] exp_v,
                             logic [SHOWN_LEDS-1:0] act_v);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch on %s: expected %b, got %b",
                         $time, what, exp_v, act_v);
        endfunction

        function void compare_status(logic [SHOWN_LEDS-1:0] on,
                                     logic [SHOWN_LEDS-1:0] pin,
                                     logic [SHOWN_LEDS-1:0] blink);
            led_status_t s;
            results_seen++;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result word with no status expected", $time);
                return;
            end
            s = expected_status.pop_front();
            if (on !== s.on)
                report("led_on", s.on, on);
            if (pin !== s.pin)
                report("pin_level", s.pin, pin);
            if (blink !== s.blink)
                report("blinking", s.blink, blink);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [KIND_W-1:0] kind;
    logic [INDEX_W-1:0] led_index;
    logic [COUNT_W-1:0] blink_count;
    logic [FIELD_PERIOD_W-1:0] blink_period;
    logic result_valid;
    logic result_stall;
    logic [SHOWN_LEDS-1:0] led_on;
    logic [SHOWN_LEDS-1:0] pin_level;
    logic [SHOWN_LEDS-1:0] blinking;

    int send_idle_pct;
    int recv_stall_pct;
    led_state_tracker tracker = new();

    multi_led_blink_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .led_index    (led_index),
        .blink_count  (blink_count),
        .blink_period (blink_period),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .led_on       (led_on),
        .pin_level    (pin_level),
        .blinking     (blinking)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            tracker.apply_word(kind, led_index, blink_count, blink_period);
        if (rst_n && result_valid && !result_stall)
            tracker.compare_status(led_on, pin_level, blinking);
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_word(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
                             logic [COUNT_W-1:0] cnt,
                             logic [FIELD_PERIOD_W-1:0] per);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        led_index    <= idx;
        blink_count  <= cnt;
        blink_period <= per;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // The sender holds off until every queued status has been checked.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed_words();
        send_word(KIND_ON, 2'd0, '0, '0);
        send_word(KIND_ON, 2'd3, '0, '0);
        send_word(KIND_TOGGLE, 2'd1, '0, '0);
        send_word(KIND_OFF, 2'd0, '0, '0);
        send_word(KIND_TOGGLE, 2'd3, '1, '1);
        // A blink with zero period only lights the LED.
        send_word(KIND_BLINK, 2'd2, '0, '0);
        // One blink: a single toggle, after which the sequence ends dark.
        send_word(KIND_BLINK, 2'd1, 8'd1, 16'd1);
        send_word(KIND_TICK, 2'd0, '0, '0);
        send_word(KIND_TICK, 2'd0, '0, '0);
        send_word(KIND_BLINK, 2'd0, '0, 16'd2);
        repeat (3)
            send_word(KIND_TICK, 2'd0, '0, '0);
        send_word(KIND_BLINK, 2'd3, '1, '1);
        send_word(KIND_UNUSED_FIRST, 2'd1, '1, '1);
        send_word(KIND_UNUSED_FIRST + 1'b1, 2'd2, '1, '1);
        send_word(KIND_UNUSED_LAST, 2'd3, '1, '1);
        send_word(KIND_TICK, 2'd3, '1, '1);
        send_word(KIND_BLINK, 2'd2, 8'd2, 16'd1);
        repeat (4)
            send_word(KIND_TICK, 2'd0, '0, '0);
        send_word(KIND_OFF, 2'd0, '0, '0);
        send_word(KIND_ON, 2'd3, '0, '0);
    endtask

    // Mostly ticks and short blink sequences, so that counted sequences run
    // out and endless ones keep toggling; some words carry full-range fields.
    task automatic random_word();
        int r;
        logic [KIND_W-1:0] k;
        logic [COUNT_W-1:0] c;
        logic [FIELD_PERIOD_W-1:0] p;
        r = $urandom_range(99);
        if (r < 50)
            k = KIND_TICK;
        else if (r < 72)
            k = KIND_BLINK;
        else if (r < 78)
            k = KIND_ON;
        else if (r < 84)
            k = KIND_OFF;
        else if (r < 93)
            k = KIND_TOGGLE;
        else
            k = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
        r = $urandom_range(99);
        if (r < 70)
            c = COUNT_W'($urandom_range(4));
        else if (r < 88)
            c = COUNT_W'($urandom);
        else
            c = '1;
        r = $urandom_range(99);
        if (r < 75)
            p = FIELD_PERIOD_W'($urandom_range(6, 1));
        else if (r < 83)
            p = '0;
        else if (r < 95)
            p = FIELD_PERIOD_W'($urandom);
        else
            p = '1;
        send_word(k, INDEX_W'($urandom_range(SHOWN_LEDS - 1)), c, p);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        kind           = KIND_TICK;
        led_index      = '0;
        blink_count    = '0;
        blink_period   = '0;
        result_stall   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 10 : 0;
            if (phase == 0)
                directed_words();
            repeat (RANDOM_PER_PHASE)
                random_word();
            drain_results();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Covered %0d words: %0d ticks, %0d blink, %0d on/off/toggle, %0d unused kinds.",
                 tracker.ticks + tracker.blinks + tracker.plain_cmds + tracker.unused_words,
                 tracker.ticks, tracker.blinks, tracker.plain_cmds, tracker.unused_words);
        $display("%0d counted blink sequences ran out; %0d result words checked, %0d errors.",
                 tracker.finished_sequences, tracker.results_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("multi_led_blink_controller test passed");
        else
            $display("multi_led_blink_controller test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d status words still expected.", tracker.pending());
        $display("multi_led_blink_controller test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mlbc_pkg.sv
rtl/mlbc_led.sv
rtl/multi_led_blink_controller.sv
tb/testbench.sv
